// ----- rtl/core/epq_pkg.sv -----
package epq_pkg;

   localparam int unsigned TICK_W    = 32;
   localparam int unsigned ELAPSED_W = 16;
   localparam int unsigned MODE_W    = 2;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DAT_W = 32;

   typedef enum logic [MODE_W-1:0] {
      MODE_IDLE  = 2'd0,
      MODE_TRUE  = 2'd1,
      MODE_FALSE = 2'd2,
      MODE_BOTH  = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PULSE_MODE    = 2'd0,
      CSR_INVERT_LEVEL  = 2'd1,
      CSR_TAP_ENABLE    = 2'd2,
      CSR_REPEAT_PERIOD = 2'd3
   } csr_idx_type;

   typedef struct packed {
      mode_type          pulse_mode;
      logic              invert_level;
      logic              tap_enable;
      logic [TICK_W-1:0] repeat_period;
   } cfg_type;

endpackage

// ----- rtl/core/epq_req_if.sv -----
interface epq_req_if
   import epq_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic                 restart;
   logic                 raw_level;
   logic [ELAPSED_W-1:0] elapsed_ticks;

   modport source (output valid, output restart, output raw_level, output elapsed_ticks,
                   input ready);
   modport sink   (input valid, input restart, input raw_level, input elapsed_ticks,
                   output ready);
endinterface

// ----- rtl/core/epq_rsp_if.sv -----
interface epq_rsp_if;
   logic valid;
   logic ready;
   logic fire;
   logic level_out;

   modport source (output valid, output fire, output level_out, input ready);
   modport sink   (input valid, input fire, input level_out, output ready);
endinterface

// ----- rtl/core/epq_csr.sv -----
module epq_csr
   import epq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wr_data,
   output cfg_type              cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_PULSE_MODE:    cfg_in.pulse_mode    = mode_type'(csr_wr_data[MODE_W-1:0]);
            CSR_INVERT_LEVEL:  cfg_in.invert_level  = csr_wr_data[0];
            CSR_TAP_ENABLE:    cfg_in.tap_enable    = csr_wr_data[0];
            CSR_REPEAT_PERIOD: cfg_in.repeat_period = csr_wr_data[TICK_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{pulse_mode: MODE_IDLE, invert_level: 1'b0, tap_enable: 1'b0,
                     repeat_period: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/core/epq_core.sv -----
module epq_core
   import epq_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   epq_req_if.sink   req_ch,
   epq_rsp_if.source rsp_ch
);

   // input register
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_restart_ff;
   logic                 s1_raw_ff;
   logic [ELAPSED_W-1:0] s1_elapsed_ff;

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_fire_ff;
   logic rsp_level_ff;

   // qualifier state
   logic              first_pass_ff, first_pass_in;
   logic              held_ff, held_in;
   logic              armed_ff, armed_in;
   logic              was_in_ff, was_in_in;
   logic [TICK_W-1:0] tick_ff, tick_in;

   logic              out_adv, s1_adv, req_take;
   logic              fp, held_pre, armed_pre, lvl, changed, mode_rep;
   logic [TICK_W:0]   sum_wide;
   logic [TICK_W-1:0] sum_sat, tick_acc;
   logic              evaluate, repeat_flag, dispatch_eval, dispatch_tap, fire_c;

   assign out_adv      = !rsp_valid_ff || rsp_ch.ready;
   assign s1_adv       = s1_valid_ff && out_adv;
   assign req_ch.ready = !s1_valid_ff || out_adv;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign s1_valid_in  = req_take || (s1_valid_ff && !out_adv);
   assign rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_ch.ready);

   // qualification of the word in the input register
   always_comb begin
      fp        = s1_restart_ff | first_pass_ff;
      held_pre  = !s1_restart_ff & held_ff;
      armed_pre = s1_restart_ff | armed_ff;
      lvl       = s1_raw_ff ^ cfg.invert_level;
      changed   = held_pre != lvl;
      mode_rep  = (cfg.pulse_mode == MODE_TRUE) || (cfg.pulse_mode == MODE_BOTH);

      sum_wide = {1'b0, tick_ff} + {{(TICK_W + 1 - ELAPSED_W){1'b0}}, s1_elapsed_ff};
      sum_sat  = sum_wide[TICK_W] ? {TICK_W{1'b1}} : sum_wide[TICK_W-1:0];
      tick_acc = fp ? tick_ff : sum_sat;

      evaluate    = fp || (sum_sat >= cfg.repeat_period) ||
                    (cfg.pulse_mode == MODE_IDLE) || changed;
      repeat_flag = evaluate && (tick_acc > cfg.repeat_period);
      tick_in     = evaluate ? '0 : tick_acc;

      dispatch_eval = 1'b0;
      if (evaluate) begin
         unique case (cfg.pulse_mode)
            MODE_IDLE:  dispatch_eval = changed;
            MODE_TRUE:  dispatch_eval = changed | lvl;
            MODE_FALSE: dispatch_eval = changed | !lvl;
            MODE_BOTH:  dispatch_eval = 1'b1;
            default:    dispatch_eval = changed;
         endcase
      end

      // one-shot tap: press pulse, then a release pulse
      held_in      = lvl;
      armed_in     = armed_pre;
      was_in_in    = was_in_ff;
      dispatch_tap = dispatch_eval;
      if (cfg.tap_enable) begin
         priority if (armed_pre && lvl) begin
            dispatch_tap = 1'b1;
            held_in      = 1'b1;
            armed_in     = 1'b0;
            was_in_in    = 1'b1;
         end else if (was_in_ff) begin
            dispatch_tap = 1'b1;
            held_in      = 1'b0;
            armed_in     = mode_rep ? 1'b1 : armed_pre;
            was_in_in    = 1'b0;
         end else begin
            dispatch_tap = 1'b0;
            held_in      = 1'b0;
            armed_in     = !lvl ? 1'b1 : armed_pre;
         end
      end

      first_pass_in = 1'b0;
      fire_c        = dispatch_tap || (mode_rep && held_in && repeat_flag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         first_pass_ff <= 1'b1;
         held_ff       <= 1'b0;
         armed_ff      <= 1'b1;
         was_in_ff     <= 1'b0;
         tick_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_adv) begin
            first_pass_ff <= first_pass_in;
            held_ff       <= held_in;
            armed_ff      <= armed_in;
            was_in_ff     <= was_in_in;
            tick_ff       <= tick_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_restart_ff <= req_ch.restart;
         s1_raw_ff     <= req_ch.raw_level;
         s1_elapsed_ff <= req_ch.elapsed_ticks;
      end
      if (s1_adv) begin
         rsp_fire_ff  <= fire_c;
         rsp_level_ff <= held_in;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.fire      = rsp_fire_ff;
   assign rsp_ch.level_out = rsp_level_ff;

endmodule

// ----- rtl/core/event_pulse_trigger_qualifier.sv -----
// Channel  Dir  Handshake      Word
// req_ch   in   valid/ready    restart, raw_level, elapsed_ticks[15:0]
// rsp_ch   out  valid/ready    fire, level_out
// csr      in   csr_wr_en      csr_index[1:0], csr_wr_data[31:0]
//
// One word in, one word out: the input register, then the qualifier logic
// (32-bit saturating tick add plus period compares) into the result
// register. A new word is taken every cycle unless rsp_ch stalls.
// reset is synchronous, active high; it clears the config registers and the
// qualifier state (first pass set, tap armed, tick count zero).
// A stalled rsp_ch holds the result register; the input register keeps
// accepting until it is also full, then req_ch.ready drops.
module event_pulse_trigger_qualifier
   import epq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   epq_req_if.sink              req_ch,
   epq_rsp_if.source            rsp_ch,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wr_data
);

   cfg_type cfg;

   // config registers; the user must write them only while the pipeline is empty (not enforced here)
   epq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   // two-stage qualifier pipeline holding the per-stream state
   epq_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

endmodule
